@@ rtl/core/fpes_pkg.sv @@
// Shared types and constants of the front panel encoder scanner.
package fpes_pkg;

   localparam int NUM_ENCODERS_DEF = 7;
   localparam int MAX_ENCODERS     = 7;

   localparam int PANEL_W  = 25;
   localparam int DIRECT_W = 3;
   localparam int TIME_W   = 32;
   localparam int THRESH_W = 16;
   localparam int STEP_W   = 8;
   localparam int PRESS_W  = 4;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 16;

   localparam logic [7:0] HIST_UP   = 8'b1000_0111;
   localparam logic [7:0] HIST_DOWN = 8'b0100_1011;

   localparam int BIT_STORE = 23;
   localparam int BIT_EXIT  = 22;
   localparam int BIT_PREV  = 24;

   localparam logic [PRESS_W-1:0] PRESS_NONE      = 4'd0;
   localparam logic [PRESS_W-1:0] PRESS_STORE     = 4'd1;
   localparam logic [PRESS_W-1:0] PRESS_EXIT      = 4'd2;
   localparam logic [PRESS_W-1:0] PRESS_PREV      = 4'd3;
   localparam logic [PRESS_W-1:0] PRESS_PUSH_BASE = 4'd4;

   localparam logic [CSR_IDX_W-1:0] CSR_FAST_THRESHOLD = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_STEP_SLOW      = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_STEP_FAST      = 2'd2;

   localparam logic [THRESH_W-1:0] THRESH_RESET    = 16'd100;
   localparam logic [STEP_W-1:0]   STEP_SLOW_RESET = 8'd1;
   localparam logic [STEP_W-1:0]   STEP_FAST_RESET = 8'd5;

   typedef struct packed {
      logic [PANEL_W-1:0]  panel_bits;
      logic [DIRECT_W-1:0] direct_buttons;
      logic [TIME_W-1:0]   now_ms;
   } req_type;

   typedef struct packed {
      logic [MAX_ENCODERS-1:0] turned_up;
      logic [MAX_ENCODERS-1:0] turned_down;
      logic                    turning_fast;
      logic [STEP_W-1:0]       step_size;
      logic [PRESS_W-1:0]      panel_press;
      logic [DIRECT_W-1:0]     direct_press;
   } rsp_type;

   typedef struct packed {
      logic                changed;
      logic [PRESS_W-1:0]  panel_press;
      logic [DIRECT_W-1:0] direct_press;
   } btn_status_type;

endpackage

@@ rtl/core/fpes_encoder_bank.sv @@
// Quadrature state tracking and detent detection for the rotary encoders.
module fpes_encoder_bank #(
   parameter int NUM_ENCODERS = fpes_pkg::NUM_ENCODERS_DEF
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 update,
   input  logic                                 decode_en,
   input  logic [fpes_pkg::PANEL_W-1:0]         panel_bits,
   output logic [fpes_pkg::MAX_ENCODERS-1:0]    turned_up,
   output logic [fpes_pkg::MAX_ENCODERS-1:0]    turned_down
);
   import fpes_pkg::*;

   for (genvar k = 0; k < MAX_ENCODERS; k++) begin : g_enc
      if (k < NUM_ENCODERS) begin : g_used
         logic [1:0] state_ff;
         logic [7:0] hist_ff;
         logic [1:0] state_now;
         logic [7:0] hist_in;
         logic       moved;

         assign state_now = {panel_bits[3*k+1], panel_bits[3*k+2]};
         assign moved     = decode_en && (state_now != state_ff);
         assign hist_in   = {hist_ff[5:0], state_now};

         assign turned_up[k]   = moved && (hist_in == HIST_UP);
         assign turned_down[k] = moved && (hist_in == HIST_DOWN);

         always_ff @(posedge clock) begin
            if (reset) begin
               state_ff <= 2'b00;
               hist_ff  <= 8'h00;
            end else if (update) begin
               if (moved) begin
                  hist_ff <= hist_in;
               end
               if (decode_en) begin
                  state_ff <= state_now;
               end
            end
         end
      end else begin : g_unused
         assign turned_up[k]   = 1'b0;
         assign turned_down[k] = 1'b0;
      end
   end

endmodule

@@ rtl/core/fpes_button_edge.sv @@
// Falling edges of panel and direct buttons; priority encoding of panel presses.
module fpes_button_edge #(
   parameter int NUM_ENCODERS = fpes_pkg::NUM_ENCODERS_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            update,
   input  logic [fpes_pkg::PANEL_W-1:0]    panel_bits,
   input  logic [fpes_pkg::DIRECT_W-1:0]   direct_buttons,
   output fpes_pkg::btn_status_type        status
);
   import fpes_pkg::*;

   logic [PANEL_W-1:0]  prev_panel_ff;
   logic [DIRECT_W-1:0] prev_direct_ff;
   logic [PANEL_W-1:0]  falling;
   logic [PRESS_W-1:0]  press;

   assign falling = prev_panel_ff & ~panel_bits;

   always_comb begin
      press = PRESS_NONE;
      for (int k = NUM_ENCODERS - 1; k >= 0; k--) begin
         if (falling[3*k+3]) begin
            press = PRESS_PUSH_BASE + PRESS_W'(k);
         end
      end
      if (falling[BIT_PREV]) begin
         press = PRESS_PREV;
      end
      if (falling[BIT_EXIT]) begin
         press = PRESS_EXIT;
      end
      if (falling[BIT_STORE]) begin
         press = PRESS_STORE;
      end
   end

   assign status.changed      = (panel_bits != prev_panel_ff);
   assign status.panel_press  = press;
   assign status.direct_press = prev_direct_ff & ~direct_buttons;

   always_ff @(posedge clock) begin
      if (reset) begin
         prev_panel_ff  <= '0;
         prev_direct_ff <= '1;
      end else if (update) begin
         prev_panel_ff  <= panel_bits;
         prev_direct_ff <= direct_buttons;
      end
   end

endmodule

@@ rtl/core/fpes_speed.sv @@
// Turning speed tracking from the interval between detents.
module fpes_speed (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                update,
   input  logic [fpes_pkg::MAX_ENCODERS-1:0]   detents,
   input  logic [fpes_pkg::TIME_W-1:0]         now_ms,
   input  logic [fpes_pkg::THRESH_W-1:0]       threshold,
   output logic                                fast_next
);
   import fpes_pkg::*;

   logic [TIME_W-1:0] last_time_ff;
   logic              fast_ff;
   logic [TIME_W-1:0] elapsed;
   logic              any_detent;
   logic              multi_detent;

   assign elapsed      = now_ms - last_time_ff;
   assign any_detent   = |detents;
   assign multi_detent = |(detents & (detents - MAX_ENCODERS'(1)));

   // Any detent after the first in one scan sees an elapsed time of zero.
   always_comb begin
      if (!any_detent) begin
         fast_next = fast_ff;
      end else if (multi_detent) begin
         fast_next = (threshold != '0);
      end else begin
         fast_next = (elapsed < {{(TIME_W-THRESH_W){1'b0}}, threshold});
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         last_time_ff <= '0;
         fast_ff      <= 1'b0;
      end else if (update) begin
         fast_ff <= fast_next;
         if (any_detent) begin
            last_time_ff <= now_ms;
         end
      end
   end

endmodule

@@ rtl/core/front_panel_encoder_scanner.sv @@
// Front panel scanner: rotary encoder detents, turning speed and button presses.
//
// Each request on the req_ channel is one scan of the panel: a 25-bit
// snapshot, three active-low direct button levels and the millisecond time.
// Every request produces exactly one response on the rsp_ channel, in order,
// with the up and down detent masks, the turning speed and step size, the
// highest priority panel press and the direct button falling edges.
// A request is registered on acceptance and decoded from the input register
// against the encoder, speed and button state once the response register is
// free; the response is registered there. While rsp_ready stays high, one
// request is taken every cycle; the rate is set by the single decode stage.
// While the receiver holds rsp_ready low, the response stays in its register
// and one further request is held in the input register before req_ready
// drops. Synchronous reset clears the encoder histories and speed state, sets
// the remembered levels to panel low and direct high and loads the register
// defaults: threshold 100 ms, slow step 1 and fast step 5. The csr_ port writes
// these registers directly and is meant to be used only while no request is in flight.
module front_panel_encoder_scanner #(
   parameter int NUM_ENCODERS = fpes_pkg::NUM_ENCODERS_DEF
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_ready,
   input  fpes_pkg::req_type                  req_data,
   output logic                               rsp_valid,
   input  logic                               rsp_ready,
   output fpes_pkg::rsp_type                  rsp_data,
   input  logic                               csr_we,
   input  logic [fpes_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [fpes_pkg::CSR_DATA_W-1:0]    csr_wdata
);
   import fpes_pkg::*;

   logic           in_valid_ff;
   logic           in_valid_in;
   req_type        in_data_ff;
   logic           rsp_valid_ff;
   logic           rsp_valid_in;
   rsp_type        rsp_data_ff;
   rsp_type        rsp_data_in;
   logic           advance;

   logic [THRESH_W-1:0] threshold_ff;
   logic [STEP_W-1:0]   step_slow_ff;
   logic [STEP_W-1:0]   step_fast_ff;

   logic [MAX_ENCODERS-1:0] turned_up;
   logic [MAX_ENCODERS-1:0] turned_down;
   btn_status_type          btn_status;
   logic                    fast_next;

   assign advance   = in_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready = !in_valid_ff || advance;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   always_comb begin
      if (req_valid && req_ready) begin
         in_valid_in = 1'b1;
      end else if (advance) begin
         in_valid_in = 1'b0;
      end else begin
         in_valid_in = in_valid_ff;
      end
      if (advance) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   fpes_button_edge #(.NUM_ENCODERS(NUM_ENCODERS)) u_buttons (
      .clock          (clock),
      .reset          (reset),
      .update         (advance),
      .panel_bits     (in_data_ff.panel_bits),
      .direct_buttons (in_data_ff.direct_buttons),
      .status         (btn_status)
   );

   fpes_encoder_bank #(.NUM_ENCODERS(NUM_ENCODERS)) u_encoders (
      .clock       (clock),
      .reset       (reset),
      .update      (advance),
      .decode_en   (btn_status.changed),
      .panel_bits  (in_data_ff.panel_bits),
      .turned_up   (turned_up),
      .turned_down (turned_down)
   );

   fpes_speed u_speed (
      .clock     (clock),
      .reset     (reset),
      .update    (advance),
      .detents   (turned_up | turned_down),
      .now_ms    (in_data_ff.now_ms),
      .threshold (threshold_ff),
      .fast_next (fast_next)
   );

   always_comb begin
      rsp_data_in.turned_up    = turned_up;
      rsp_data_in.turned_down  = turned_down;
      rsp_data_in.turning_fast = fast_next;
      rsp_data_in.step_size    = fast_next ? step_fast_ff : step_slow_ff;
      rsp_data_in.panel_press  = btn_status.panel_press;
      rsp_data_in.direct_press = btn_status.direct_press;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         in_data_ff <= req_data;
      end
      if (advance) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         threshold_ff <= THRESH_RESET;
         step_slow_ff <= STEP_SLOW_RESET;
         step_fast_ff <= STEP_FAST_RESET;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_FAST_THRESHOLD: threshold_ff <= csr_wdata[THRESH_W-1:0];
            CSR_STEP_SLOW:      step_slow_ff <= csr_wdata[STEP_W-1:0];
            CSR_STEP_FAST:      step_fast_ff <= csr_wdata[STEP_W-1:0];
            default: begin
            end
         endcase
      end
   end

endmodule
